// ----- src/nfa_pkg.sv -----
// ----------------------------------------------------------------------------
// nfa_pkg - next-fit ID allocator shared definitions
// Widths, request and response codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package nfa_pkg;

	localparam int ID_W     = 8;
	localparam int ID_COUNT = 1 << ID_W;
	localparam int WORD_W   = 16;
	localparam int BIT_W    = $clog2(WORD_W);
	localparam int WORDS    = ID_COUNT / WORD_W;
	localparam int ADDR_W   = $clog2(WORDS);
	localparam int STEP_W   = ADDR_W + 1;
	localparam int STAT_W   = 2;

	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(WORDS);

	typedef enum logic {
		REQ_ALLOC   = 1'b0,
		REQ_RELEASE = 1'b1
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		RSP_OK          = 2'd0,
		RSP_FULL        = 2'd1,
		RSP_BAD_RELEASE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ALLOC,
		S_RELEASE
	} state_t;

	typedef struct packed {
		logic load;
		logic advance;
		logic commit_alloc;
		logic commit_release;
	} nfa_cmd_t;

	typedef struct packed {
		logic hit;
		logic last_step;
		logic out_free;
	} nfa_stat_t;

	// index of the lowest set bit; zero when none set
	function automatic logic [BIT_W-1:0] first_set(input logic [WORD_W-1:0] v);
		logic [BIT_W-1:0] r;
		r = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = BIT_W'(i);
			end
		end
		return r;
	endfunction

endpackage

// ----- src/nfa_req_if.sv -----
// ----------------------------------------------------------------------------
// nfa_req_if - request channel
// valid/ready channel carrying an allocate or release request.
// ----------------------------------------------------------------------------
interface nfa_req_if import nfa_pkg::*; ;
	logic            valid;
	logic            ready;
	logic            req_type;
	logic [ID_W-1:0] release_id;

	modport source (output valid, output req_type, output release_id, input ready);
	modport sink   (input valid, input req_type, input release_id, output ready);
endinterface

// ----- src/nfa_rsp_if.sv -----
// ----------------------------------------------------------------------------
// nfa_rsp_if - response channel
// valid/ready channel carrying the granted ID and completion status.
// ----------------------------------------------------------------------------
interface nfa_rsp_if import nfa_pkg::*; ;
	logic              valid;
	logic              ready;
	logic [ID_W-1:0]   granted_id;
	logic [STAT_W-1:0] status;

	modport source (output valid, output granted_id, output status, input ready);
	modport sink   (input valid, input granted_id, input status, output ready);
endinterface

// ----- src/nfa_ctrl.sv -----
// ----------------------------------------------------------------------------
// nfa_ctrl - allocator controller
// Accepts one request at a time and steps the datapath through the
// word scan or the single-word release.
// ----------------------------------------------------------------------------
module nfa_ctrl import nfa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_req_type,
	output logic      in_ready,
	input  nfa_stat_t stat,
	output nfa_cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = (in_req_type == REQ_RELEASE) ? S_RELEASE : S_ALLOC;
				end
			end
			S_ALLOC: begin
				if (stat.hit || stat.last_step) begin
					if (stat.out_free) begin
						cmd.commit_alloc = 1'b1;
						state_d          = S_IDLE;
					end
				end else begin
					cmd.advance = 1'b1;
				end
			end
			S_RELEASE: begin
				if (stat.out_free) begin
					cmd.commit_release = 1'b1;
					state_d            = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ----- src/nfa_dp.sv -----
// ----------------------------------------------------------------------------
// nfa_dp - allocator datapath
// In-use bitmap held as 16-bit words, next-fit word scan with start
// and wrap masks, release check and the registered response beat.
// ----------------------------------------------------------------------------
module nfa_dp import nfa_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_req_type,
	input  logic [ID_W-1:0] in_release_id,
	input  nfa_cmd_t        cmd,
	output nfa_stat_t       stat,
	nfa_rsp_if.source       rsp
);

	logic [WORD_W-1:0] map_q [WORDS];
	logic [ID_W-1:0]   last_q;
	logic [ID_W-1:0]   start_q;
	logic [ID_W-1:0]   rel_id_q;
	logic              rel_q;
	logic [STEP_W-1:0] step_q;

	logic              out_valid_q;
	logic [ID_W-1:0]   granted_q;
	status_t           status_q;

	logic [ADDR_W-1:0] addr;
	logic [ADDR_W-1:0] scan_addr;
	logic [WORD_W-1:0] word;
	logic [WORD_W-1:0] mask;
	logic [WORD_W-1:0] free_bits;
	logic [BIT_W-1:0]  hit_bit;
	logic [BIT_W-1:0]  start_bit;
	logic [BIT_W-1:0]  rel_bit;
	logic              rel_bad;
	logic              out_free;

	assign start_bit = start_q[BIT_W-1:0];
	assign rel_bit   = rel_id_q[BIT_W-1:0];
	assign scan_addr = start_q[ID_W-1:BIT_W] + step_q[ADDR_W-1:0];
	assign addr      = rel_q ? rel_id_q[ID_W-1:BIT_W] : scan_addr;
	assign word      = map_q[addr];

	always_comb begin
		if (step_q == '0) begin
			mask = {WORD_W{1'b1}} << start_bit;
		end else if (step_q == LAST_STEP) begin
			mask = ~({WORD_W{1'b1}} << start_bit);
		end else begin
			mask = {WORD_W{1'b1}};
		end
		// ID 0 is reserved
		if (addr == '0) begin
			mask[0] = 1'b0;
		end
	end

	assign free_bits = ~word & mask;
	assign hit_bit   = first_set(free_bits);
	assign rel_bad   = (rel_id_q == '0) || !word[rel_bit];
	assign out_free  = !out_valid_q || rsp.ready;

	assign stat.hit       = |free_bits;
	assign stat.last_step = (step_q == LAST_STEP);
	assign stat.out_free  = out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WORDS; i++) begin
				map_q[i] <= '0;
			end
			last_q <= '0;
		end else if (cmd.commit_alloc && stat.hit) begin
			map_q[addr][hit_bit] <= 1'b1;
			last_q               <= {addr, hit_bit};
		end else if (cmd.commit_release && !rel_bad) begin
			map_q[addr][rel_bit] <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			rel_q  <= 1'b0;
		end else if (cmd.load) begin
			step_q <= '0;
			rel_q  <= (in_req_type == REQ_RELEASE);
		end else if (cmd.advance) begin
			step_q <= step_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			start_q  <= last_q + 1'b1;
			rel_id_q <= in_release_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit_alloc || cmd.commit_release) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit_alloc) begin
			granted_q <= stat.hit ? {addr, hit_bit} : '0;
			status_q  <= stat.hit ? RSP_OK : RSP_FULL;
		end else if (cmd.commit_release) begin
			granted_q <= '0;
			status_q  <= rel_bad ? RSP_BAD_RELEASE : RSP_OK;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.granted_id = granted_q;
	assign rsp.status     = status_q;

	a_id0_free: assert property (@(posedge clk) disable iff (!arst_n)
		!map_q[0][0])
		else $error("reserved ID marked in use");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= LAST_STEP)
		else $error("scan step out of range");

	a_commit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit_alloc || cmd.commit_release) |-> out_free)
		else $error("response overwritten before taken");

	a_grant_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit_alloc && stat.hit) |=> (rsp.granted_id != '0 && last_q == rsp.granted_id))
		else $error("grant not recorded");

endmodule

// ----- src/next_fit_id_allocator.sv -----
// Allocate: the accepted request beat is latched, then the scan reads one 16-bit bitmap
//   word per step (up to 17 words; the start word is visited twice for the bits below
//   the start point) and the response beat is registered once the output slot is free.
// Release: latch, then one word read-modify-write once the output slot is free.
// One request in flight; a new one is taken while the response waits.
// Reset clears the in-use bitmap in flip-flops at once and last granted to 0.
// ----------------------------------------------------------------------------
// next_fit_id_allocator - next-fit bitmap ID allocator
// Grants the first free ID after the last granted one, wrapping and never
// granting ID 0; releases flag IDs that are not in use.
// ----------------------------------------------------------------------------
module next_fit_id_allocator import nfa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	nfa_req_if.sink   req,
	nfa_rsp_if.source rsp
);

	nfa_cmd_t  cmd;
	nfa_stat_t stat;
	logic      in_ready;

	assign req.ready = in_ready;

	nfa_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (req.valid),
		.in_req_type (req.req_type),
		.in_ready    (in_ready),
		.stat        (stat),
		.cmd         (cmd)
	);

	nfa_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_req_type   (req.req_type),
		.in_release_id (req.release_id),
		.cmd           (cmd),
		.stat          (stat),
		.rsp           (rsp)
	);

endmodule
